[design/rled_pkg.sv]
// ----------------------------------------------------------------------------
// rled_pkg
// Shared types and constants for the escape-byte run-length decoder.
// ----------------------------------------------------------------------------
package rled_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 4;
    localparam int WORD_W  = 64;
    localparam int TOT_W   = 25;
    localparam int LIMIT_W = 25;

    localparam logic [BYTE_W-1:0]  ESC_RESET   = 8'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd16777216;

    // configuration register indexes
    localparam logic CFG_ESCAPE = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    // decode phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic step;     // emit next word of a pending run
    } t_cmd;

    typedef struct packed {
        logic slot_free;  // output register can load this cycle
        logic more;       // run continues after the word formed now
    } t_stat;

endpackage

[design/rle_escape_byte_decoder.sv]
// ----------------------------------------------------------------------------
// rle_escape_byte_decoder
// Escape-byte run-length decoder, output packed up to BPW bytes per word.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  in       | i_in_valid  / o_in_ready   | i_in_byte, i_last_byte
//  out      | o_out_valid / i_out_ready  | o_data_word .. o_truncated_run
//
//  Literal, escape and count words are taken back to back. A run word expands
//  into ceil(n / BPW) packed words, n = count cut at the output limit; the run
//  stepper emits one packed word per cycle unless out stalls, holding input.
//  Output is registered; a stalled out channel holds the decoder in place.
//  Config is taken only while idle, output empty and no input word offered.
//  Reset is synchronous: decode state cleared, escape 2, limit 2^24.
// ----------------------------------------------------------------------------
module rle_escape_byte_decoder #(
    parameter int BPW = 8,
    parameter int TB  = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [rled_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rled_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rled_pkg::WORD_W-1:0]   o_data_word,
    output logic [rled_pkg::CNT_W-1:0]    o_byte_count,
    output logic                          o_run_done,
    output logic                          o_stream_end,
    output logic [rled_pkg::TOT_W-1:0]    o_total_out,
    output logic                          o_limit_reached,
    output logic                          o_truncated_run
);
    import rled_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;

    assign o_cfg_ready = o_in_ready && !o_out_valid && !i_in_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    rled_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rled_dpath #(
        .BPW (BPW),
        .TB  (TB)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_wr),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_byte       (i_in_byte),
        .i_last_byte     (i_last_byte),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_word     (o_data_word),
        .o_byte_count    (o_byte_count),
        .o_run_done      (o_run_done),
        .o_stream_end    (o_stream_end),
        .o_total_out     (o_total_out),
        .o_limit_reached (o_limit_reached),
        .o_truncated_run (o_truncated_run)
    );

`ifndef SYNTH
    a_in_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (!o_out_valid || i_out_ready))
        else $error("input word taken while output slot busy");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_count <= CNT_W'(BPW)))
        else $error("byte count above word size");

    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_end) |-> o_run_done)
        else $error("stream end without run done");

    a_trunc_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truncated_run) |-> (o_stream_end && (o_byte_count == '0)))
        else $error("truncated flag on a data word");
`endif

endmodule

[design/rled_ctrl.sv]
// ----------------------------------------------------------------------------
// rled_ctrl
// Controller: takes input words while idle, steps through run words.
// ----------------------------------------------------------------------------
module rled_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rled_pkg::t_stat i_stat,
    output rled_pkg::t_cmd  o_cmd
);
    import rled_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready   = (r_state == S_IDLE) && i_stat.slot_free;
    assign o_cmd.accept = o_in_ready && i_in_valid;
    assign o_cmd.step   = (r_state == S_RUN) && i_stat.slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_stat.more) n_state = S_RUN;
            end
            S_RUN: begin
                if (o_cmd.step && !i_stat.more) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/rled_dpath.sv]
// ----------------------------------------------------------------------------
// rled_dpath
// Datapath: config registers, decode state, word packing, limit tracking
// and the output register.
// ----------------------------------------------------------------------------
module rled_dpath #(
    parameter int BPW = 8,
    parameter int TB  = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [rled_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic [rled_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_last_byte,
    input  rled_pkg::t_cmd                i_cmd,
    output rled_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rled_pkg::WORD_W-1:0]   o_data_word,
    output logic [rled_pkg::CNT_W-1:0]    o_byte_count,
    output logic                          o_run_done,
    output logic                          o_stream_end,
    output logic [rled_pkg::TOT_W-1:0]    o_total_out,
    output logic                          o_limit_reached,
    output logic                          o_truncated_run
);
    import rled_pkg::*;

    logic [BYTE_W-1:0]  r_escape;
    logic [LIMIT_W-1:0] r_limit;
    logic [1:0]         r_phase;
    logic [BYTE_W-1:0]  r_pending;
    logic [TB-1:0]      r_bytes;
    logic               r_stopped;
    logic [BYTE_W-1:0]  r_val;
    logic [BYTE_W-1:0]  r_reps;
    logic               r_last;

    logic [1:0]         n_phase;
    logic [BYTE_W-1:0]  n_pending;
    logic [TB-1:0]      n_bytes;
    logic               n_stopped;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_word;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic               r_end;
    logic [TOT_W-1:0]   r_total;
    logic               r_hit;
    logic               r_trunc;

    logic                  lit;
    logic                  acc_emit;
    logic                  acc_trunc;
    logic [BYTE_W-1:0]     src_val;
    logic [BYTE_W-1:0]     src_reps;
    logic                  src_last;
    logic                  emit;
    logic [TB+LIMIT_W-1:0] lim_wide;
    logic [TB-1:0]         lim_raw;
    logic [TB-1:0]         lim;
    logic [TB-1:0]         rem;
    logic [CNT_W-1:0]      kk;
    logic [CNT_W-1:0]      k;
    logic                  hit;
    logic                  more;
    logic [BYTE_W-1:0]     reps_after;
    logic [TB-1:0]         new_total;
    logic                  close;
    logic                  out_load;
    logic [WORD_W-1:0]     word;
    logic [TB+TOT_W-1:0]   tot_new_wide;
    logic [TB+TOT_W-1:0]   tot_old_wide;

    assign lit       = (r_phase != PH_COUNT) && (r_phase != PH_VALUE);
    assign acc_emit  = !r_stopped && (((r_phase == PH_VALUE) && (r_pending != '0))
                       || (lit && (i_in_byte != r_escape)));
    assign acc_trunc = !r_stopped && ((r_phase == PH_COUNT)
                       || (lit && (i_in_byte == r_escape)));

    assign src_val  = i_cmd.step ? r_val : i_in_byte;
    assign src_reps = i_cmd.step ? r_reps
                    : ((r_phase == PH_VALUE) ? r_pending : 8'd1);
    assign src_last = i_cmd.step ? r_last : i_last_byte;
    assign emit     = i_cmd.step || (i_cmd.accept && acc_emit);

    // limit taken modulo 2^TB, zero acts as one
    assign lim_wide = {{TB{1'b0}}, r_limit};
    assign lim_raw  = lim_wide[TB-1:0];
    assign lim      = (lim_raw == '0) ? TB'(1) : lim_raw;
    // limit already passed: the next byte stops the stream
    assign rem      = (r_bytes >= lim) ? TB'(1) : (lim - r_bytes);

    assign kk         = (src_reps < 8'(BPW)) ? src_reps[CNT_W-1:0] : CNT_W'(BPW);
    assign k          = (rem < TB'(kk)) ? rem[CNT_W-1:0] : kk;
    assign hit        = (TB'(k) == rem);
    assign more       = emit && (src_reps != 8'(k)) && !hit;
    assign reps_after = src_reps - 8'(k);
    assign new_total  = r_bytes + TB'(k);

    assign close    = (emit && !more && src_last)
                    || (i_cmd.accept && !acc_emit && i_last_byte);
    assign out_load = emit || (i_cmd.accept && i_last_byte);

    assign tot_new_wide = {{TOT_W{1'b0}}, new_total};
    assign tot_old_wide = {{TOT_W{1'b0}}, r_bytes};

    always_comb begin
        word = '0;
        for (int i = 0; i < BPW; i++) begin
            if (CNT_W'(i) < k) word[i*BYTE_W +: BYTE_W] = src_val;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_bytes   = r_bytes;
        n_stopped = r_stopped;
        if (i_cmd.accept && !r_stopped) begin
            case (r_phase)
                PH_COUNT: begin
                    n_pending = i_in_byte;
                    n_phase   = PH_VALUE;
                end
                PH_VALUE: n_phase = PH_IDLE;
                default: begin
                    n_phase = (i_in_byte == r_escape) ? PH_COUNT : PH_IDLE;
                end
            endcase
        end
        if (emit) begin
            n_bytes   = new_total;
            n_stopped = hit;
        end
        if (close) begin
            n_phase   = PH_IDLE;
            n_pending = '0;
            n_bytes   = '0;
            n_stopped = 1'b0;
        end
    end

    assign o_stat.slot_free = !r_out_valid || i_out_ready;
    assign o_stat.more      = more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape    <= ESC_RESET;
            r_limit     <= LIMIT_RESET;
            r_phase     <= PH_IDLE;
            r_pending   <= '0;
            r_bytes     <= '0;
            r_stopped   <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ESCAPE) begin
                    r_escape <= i_cfg_data[BYTE_W-1:0];
                end else begin
                    r_limit <= i_cfg_data;
                end
            end
            if (i_cmd.accept) begin
                r_last <= i_last_byte;
            end
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_bytes   <= n_bytes;
            r_stopped <= n_stopped;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_val <= i_in_byte;
        if (emit) r_reps <= reps_after;
        if (out_load) begin
            r_word  <= emit ? word : '0;
            r_cnt   <= emit ? k : '0;
            r_done  <= !more;
            r_end   <= src_last && !more;
            r_total <= emit ? tot_new_wide[TOT_W-1:0] : tot_old_wide[TOT_W-1:0];
            r_hit   <= emit ? hit : r_stopped;
            r_trunc <= !emit && acc_trunc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_word     = r_word;
    assign o_byte_count    = r_cnt;
    assign o_run_done      = r_done;
    assign o_stream_end    = r_end;
    assign o_total_out     = r_total;
    assign o_limit_reached = r_hit;
    assign o_truncated_run = r_trunc;

endmodule

[bench/rle_escape_byte_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_escape_byte_decoder_test
// Self-checking bench for the escape-byte run-length decoder. Compressed
// streams (literals, escape/count/value runs, cut-off sequences, noise) are
// driven through the in channel under three idle mixes and a long output
// stall. A tracker expands every accepted word into the packed output words
// it should cause and checks each output word field by field, in order.
// Both registers are rewritten between phases, including their extremes.
// ----------------------------------------------------------------------------
module rle_escape_byte_decoder_test;
    import rled_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [CNT_W-1:0]  byte_count;
        logic              run_done;
        logic              stream_end;
        logic [TOT_W-1:0]  total_out;
        logic              limit_reached;
        logic              truncated_run;
    } t_dec_word;

    class decode_tracker;
        logic [BYTE_W-1:0]  esc_code;
        logic [LIMIT_W-1:0] out_limit;
        logic [1:0]         phase;
        logic [BYTE_W-1:0]  run_len;
        logic [TOT_W-1:0]   emitted;
        bit                 stopped;
        t_dec_word          batch[$];
        t_dec_word          words_due[$];
        int                 mismatches;

        function new();
            esc_code   = ESC_RESET;
            out_limit  = LIMIT_RESET;
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            phase   = PH_IDLE;
            run_len = '0;
            emitted = '0;
            stopped = 1'b0;
        endfunction

        function void set_reg(logic idx, logic [LIMIT_W-1:0] val);
            if (idx == CFG_ESCAPE) begin
                esc_code = val[BYTE_W-1:0];
            end else begin
                out_limit = val;
            end
        endfunction

        // pack reps copies of val into words, stopping at the output limit
        function void expand(logic [BYTE_W-1:0] val, int reps);
            logic [TOT_W-1:0] lim;
            t_dec_word        w;
            int               cnt;
            lim = (out_limit == '0) ? TOT_W'(1) : out_limit;
            while (reps > 0 && !stopped) begin
                w   = '0;
                cnt = 0;
                while (cnt < 8 && reps > 0 && !stopped) begin
                    w.data_word[8*cnt +: 8] = val;
                    cnt++;
                    reps--;
                    emitted = emitted + 1'b1;
                    if (emitted >= lim) stopped = 1'b1;
                end
                w.byte_count    = CNT_W'(cnt);
                w.total_out     = emitted;
                w.limit_reached = stopped;
                batch.push_back(w);
            end
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic last);
            bit        trunc;
            t_dec_word w;
            trunc = 1'b0;
            batch.delete();
            if (!stopped) begin
                case (phase)
                    PH_COUNT: begin
                        run_len = b;
                        phase   = PH_VALUE;
                        trunc   = 1'b1;
                    end
                    PH_VALUE: begin
                        phase = PH_IDLE;
                        expand(b, run_len);
                    end
                    default: begin
                        phase = PH_IDLE;
                        if (b == esc_code) begin
                            phase = PH_COUNT;
                            trunc = 1'b1;
                        end else begin
                            expand(b, 1);
                        end
                    end
                endcase
            end
            // a quiet last word still closes the stream with an empty word
            if (last && batch.size() == 0) begin
                w               = '0;
                w.total_out     = emitted;
                w.limit_reached = stopped;
                batch.push_back(w);
            end
            if (batch.size() > 0) begin
                w          = batch.pop_back();
                w.run_done = 1'b1;
                if (last) begin
                    w.stream_end    = 1'b1;
                    w.truncated_run = trunc;
                end
                batch.push_back(w);
            end
            foreach (batch[i]) words_due.push_back(batch[i]);
            if (last) clear_stream();
        endfunction

        function void report(string fld, logic [63:0] want, logic [63:0] seen);
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fld, want, seen);
            mismatches++;
        endfunction

        function void match_word(t_dec_word got);
            t_dec_word want;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word, data 0x%0h count %0d",
                         $time, got.data_word, got.byte_count);
                mismatches++;
                return;
            end
            want = words_due.pop_front();
            if (got.data_word !== want.data_word)
                report("data_word", want.data_word, got.data_word);
            if (got.byte_count !== want.byte_count)
                report("byte_count", 64'(want.byte_count), 64'(got.byte_count));
            if (got.run_done !== want.run_done)
                report("run_done", 64'(want.run_done), 64'(got.run_done));
            if (got.stream_end !== want.stream_end)
                report("stream_end", 64'(want.stream_end), 64'(got.stream_end));
            if (got.total_out !== want.total_out)
                report("total_out", 64'(want.total_out), 64'(got.total_out));
            if (got.limit_reached !== want.limit_reached)
                report("limit_reached", 64'(want.limit_reached), 64'(got.limit_reached));
            if (got.truncated_run !== want.truncated_run)
                report("truncated_run", 64'(want.truncated_run), 64'(got.truncated_run));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                i_cfg_index = CFG_ESCAPE;
    logic [LIMIT_W-1:0]  i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]   i_in_byte   = '0;
    logic                i_last_byte = 1'b0;
    logic                i_out_ready = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [WORD_W-1:0]   o_data_word;
    logic [CNT_W-1:0]    o_byte_count;
    logic                o_run_done;
    logic                o_stream_end;
    logic [TOT_W-1:0]    o_total_out;
    logic                o_limit_reached;
    logic                o_truncated_run;

    t_dec_word           out_seen;
    decode_tracker       tracker;
    logic [BYTE_W-1:0]   cur_esc;
    int                  send_idle;
    int                  recv_idle;
    int                  items_sent  = 0;
    int                  cycle_count = 0;
    int                  hold_left   = 0;
    logic                stall_req   = 1'b0;
    logic                stall_taken = 1'b0;

    rle_escape_byte_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_word     (o_data_word),
        .o_byte_count    (o_byte_count),
        .o_run_done      (o_run_done),
        .o_stream_end    (o_stream_end),
        .o_total_out     (o_total_out),
        .o_limit_reached (o_limit_reached),
        .o_truncated_run (o_truncated_run)
    );

    assign out_seen = {o_data_word, o_byte_count, o_run_done, o_stream_end,
                       o_total_out, o_limit_reached, o_truncated_run};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) tracker.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) tracker.take_byte(i_in_byte, i_last_byte);
            if (o_out_valid && i_out_ready) tracker.match_word(out_seen);
        end
    end

    // out side: random backpressure, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_req && !stall_taken) begin
            stall_taken <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] b, input logic last);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_in_valid  <= 1'b1;
        i_in_byte   <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_stream();
        logic [BYTE_W-1:0] seq[$];
        logic [BYTE_W-1:0] lit;
        int                tokens;
        int                pick;
        tokens = $urandom_range(1, 10);
        repeat (tokens) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                lit = 8'($urandom_range(255));
                if (lit == cur_esc) lit ^= 8'h01;
                seq.push_back(lit);
            end else if (pick < 88) begin
                seq.push_back(cur_esc);
                case ($urandom_range(9))
                    0:       seq.push_back(8'd0);
                    1:       seq.push_back(8'd255);
                    2:       seq.push_back(8'($urandom_range(255)));
                    default: seq.push_back(8'($urandom_range(1, 20)));
                endcase
                seq.push_back(8'($urandom));
            end else begin
                seq.push_back(8'($urandom));
            end
        end
        // some streams end inside an escape sequence
        pick = $urandom_range(99);
        if (pick < 8) begin
            seq.push_back(cur_esc);
        end else if (pick < 14) begin
            seq.push_back(cur_esc);
            seq.push_back(8'($urandom));
        end
        foreach (seq[i]) send_item(seq[i], i == seq.size() - 1);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.words_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] esc, input logic [LIMIT_W-1:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ESCAPE;
        i_cfg_data  <= LIMIT_W'(esc);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_LIMIT;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_esc = esc;
    endtask

    task automatic run_phase(input int p);
        logic [BYTE_W-1:0]  e;
        logic [LIMIT_W-1:0] l;
        int                 quota;
        settle();
        case (p % 3)
            0:       e = 8'h00;
            1:       e = 8'hFF;
            default: e = 8'($urandom_range(255));
        endcase
        case (p % 4)
            0:       l = LIMIT_RESET;
            1:       l = LIMIT_W'($urandom_range(60, 900));
            2:       l = LIMIT_W'($urandom_range(1, 24));
            default: l = (p == 3) ? LIMIT_W'(1) : LIMIT_RESET;
        endcase
        set_config(e, l);
        case (p / 3)
            0:       begin send_idle = 8;  recv_idle = 87; end
            1:       begin send_idle = 87; recv_idle = 8;  end
            default: begin send_idle = 0;  recv_idle = 0;  end
        endcase
        if (p == 6) stall_req <= 1'b1;
        quota = items_sent + 46;
        while (items_sent < quota) send_stream();
    endtask

    initial begin
        tracker   = new();
        cur_esc   = ESC_RESET;
        send_idle = 8;
        recv_idle = 87;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // literals at both extremes, stream closed on a literal
        send_item(8'h00, 0); send_item(8'hFF, 0); send_item(8'h41, 1);
        // empty run, full 255-byte run, run of the escape value itself
        send_item(8'h02, 0); send_item(8'h00, 0); send_item(8'h09, 0);
        send_item(8'h02, 0); send_item(8'hFF, 0); send_item(8'hAA, 0);
        send_item(8'h02, 0); send_item(8'h01, 0); send_item(8'h02, 0);
        // streams ending after the escape, after the count, on an empty run
        send_item(8'h02, 1);
        send_item(8'h02, 0); send_item(8'h05, 1);
        send_item(8'h02, 0); send_item(8'h00, 0); send_item(8'h07, 1);

        // zero limit acts as one; escape after stop is swallowed, no truncation
        settle();
        set_config(8'hFF, '0);
        send_item(8'h11, 0); send_item(8'h22, 0); send_item(8'hFF, 1);

        // run cut at the limit, rest of stream swallowed
        settle();
        set_config(8'h00, LIMIT_W'(10));
        send_item(8'h00, 0); send_item(8'd20, 0); send_item(8'h33, 0); send_item(8'h44, 1);

        for (int p = 0; p < 9; p++) run_phase(p);
        settle();

        if (tracker.mismatches == 0 && tracker.words_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (tracker.words_due.size() != 0)
                $display("%0t: %0d expected words never arrived",
                         $time, tracker.words_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
design/rled_pkg.sv
design/rled_ctrl.sv
design/rled_dpath.sv
design/rle_escape_byte_decoder.sv
bench/rle_escape_byte_decoder_test.sv
